// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the note latch checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define MNL_ASSERT_IMPLY(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, disabled during reset
`define MNL_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== design/mnl_pkg.sv =====
// ----------------------------------------------------------------------------
// mnl_pkg
// Codes and types shared by the MIDI note latch.
// ----------------------------------------------------------------------------
package mnl_pkg;

  localparam logic [1:0] FUNC_NOTE_ON  = 2'd0;
  localparam logic [1:0] FUNC_NOTE_OFF = 2'd1;
  localparam logic [1:0] FUNC_FLUSH    = 2'd2;

  localparam logic [1:0] IRQ_OFF = 2'd0;
  localparam logic [1:0] IRQ_ALL = 2'd1;

  localparam logic [2:0] REG_POLY_MODE   = 3'd0;
  localparam logic [2:0] REG_CHAN_LOW    = 3'd1;
  localparam logic [2:0] REG_CHAN_HIGH   = 3'd2;
  localparam logic [2:0] REG_IRQ_MODE    = 3'd3;
  localparam logic [2:0] REG_NOTE_LOW    = 3'd4;
  localparam logic [2:0] REG_NOTE_HIGH   = 3'd5;
  localparam logic [2:0] REG_VEL_LOW     = 3'd6;
  localparam logic [2:0] REG_VEL_HIGH    = 3'd7;

  localparam int CHAN_W = 4;
  localparam int NOTE_W = 7;
  localparam int ADDR_W = 5;

  typedef struct packed {
    logic              is_note_on;
    logic [CHAN_W-1:0] chan;
    logic [NOTE_W-1:0] pitch;
    logic [NOTE_W-1:0] vel;
  } res_t;

endpackage

// ===== design/midi_note_latch.sv =====
// ----------------------------------------------------------------------------
// midi_note_latch
// Latches MIDI notes in a table and emits the resulting note messages.
// ----------------------------------------------------------------------------
// One item is taken at a time; in_stall stays high until its last beat has
// left the internal holding register. Swallowed and ignored items leave
// in_stall low; pass-through items go through ST_FIN, and mono-mode note-ons
// through ST_MONO_RD and ST_MONO_CHK, then ST_FIN when they emit a beat,
// with ST_MONO_ON before it when they emit two. Poly note-ons, interrupts
// and flushes walk the whole note table through its single read port, one
// entry a cycle unless out_stall holds a beat; a held beat holds any item.
// The last beat of every item carries out_last. The note table needs no
// clearing after reset: a valid flag per entry lives in flip-flops.
module midi_note_latch #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [3:0]  in_chan,
  input  logic [6:0]  in_pitch,
  input  logic [6:0]  in_vel,
  input  logic [15:0] in_flush_mask,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_is_note_on,
  output logic [3:0]  out_chan,
  output logic [6:0]  out_pitch,
  output logic [6:0]  out_vel,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [mnl_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int IW = $clog2(TABLE_DEPTH + 1);
  localparam logic [IW-1:0] SCAN_END = IW'(TABLE_DEPTH);
  localparam int EW = mnl_pkg::CHAN_W + mnl_pkg::NOTE_W;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_REL      = 3'd1;
  localparam logic [2:0] ST_POLY     = 3'd2;
  localparam logic [2:0] ST_MONO_RD  = 3'd3;
  localparam logic [2:0] ST_MONO_CHK = 3'd4;
  localparam logic [2:0] ST_MONO_ON  = 3'd5;
  localparam logic [2:0] ST_FIN      = 3'd6;

  // configuration
  logic       poly_mode_r;
  logic [3:0] chan_lo_r, chan_hi_r;
  logic [1:0] irq_mode_r;
  logic [6:0] note_lo_r, note_hi_r, vel_lo_r, vel_hi_r;
  logic       cfg_wr;

  // sequencer and item
  logic [2:0]  state_r, state_nxt;
  logic [3:0]  chan_r, chan_nxt;
  logic [6:0]  pitch_r, pitch_nxt;
  logic [6:0]  vel_r, vel_nxt;
  logic [15:0] mask_r, mask_nxt;

  // table walk
  logic [IW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] idx_d_r, idx_d_nxt;
  logic          dv_r, dv_nxt;
  logic          match_v_r, match_v_nxt, blank_v_r, blank_v_nxt;
  logic [AW-1:0] match_r, match_nxt, blank_r, blank_nxt;
  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;

  // note table storage
  logic [EW-1:0] mem [TABLE_DEPTH];
  logic [EW-1:0] rd_data_r;
  logic          rd_en, wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic [3:0]    rd_chan;
  logic [6:0]    rd_note;

  // result holding and output
  logic                pend_v_r, pend_v_nxt;
  mnl_pkg::res_t       pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt;
  mnl_pkg::res_t       out_r, out_nxt;
  logic                out_last_r, out_last_nxt;

  logic in_acc, out_free, active, trig, hit, blocked, adv, same;
  logic [AW-1:0] mono_addr;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign rd_chan   = rd_data_r[EW-1:mnl_pkg::NOTE_W];
  assign rd_note   = rd_data_r[mnl_pkg::NOTE_W-1:0];
  assign mono_addr = AW'(chan_r);

  assign active = (in_chan >= chan_lo_r) && (in_chan <= chan_hi_r);
  assign trig   = (irq_mode_r != mnl_pkg::IRQ_OFF) &&
                  (in_pitch >= note_lo_r) && (in_pitch <= note_hi_r) &&
                  (in_vel >= vel_lo_r) && (in_vel <= vel_hi_r);

  assign hit     = (state_r == ST_REL) && dv_r && valid_r[idx_d_r] && mask_r[rd_chan];
  assign blocked = hit && pend_v_r && !out_free;
  assign adv     = !blocked;
  assign same    = valid_r[mono_addr] && (rd_note == pitch_r);

  always_comb begin
    prdata = '0;
    unique case (paddr[4:2])
      mnl_pkg::REG_POLY_MODE: prdata = 32'(poly_mode_r);
      mnl_pkg::REG_CHAN_LOW:  prdata = 32'(chan_lo_r);
      mnl_pkg::REG_CHAN_HIGH: prdata = 32'(chan_hi_r);
      mnl_pkg::REG_IRQ_MODE:  prdata = 32'(irq_mode_r);
      mnl_pkg::REG_NOTE_LOW:  prdata = 32'(note_lo_r);
      mnl_pkg::REG_NOTE_HIGH: prdata = 32'(note_hi_r);
      mnl_pkg::REG_VEL_LOW:   prdata = 32'(vel_lo_r);
      mnl_pkg::REG_VEL_HIGH:  prdata = 32'(vel_hi_r);
      default:                prdata = '0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    chan_nxt      = chan_r;
    pitch_nxt     = pitch_r;
    vel_nxt       = vel_r;
    mask_nxt      = mask_r;
    idx_nxt       = idx_r;
    idx_d_nxt     = idx_d_r;
    dv_nxt        = dv_r;
    match_v_nxt   = match_v_r;
    match_nxt     = match_r;
    blank_v_nxt   = blank_v_r;
    blank_nxt     = blank_r;
    valid_nxt     = valid_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    out_last_nxt  = out_last_r;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = mono_addr;
    wr_data       = {chan_r, pitch_r};

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          chan_nxt    = in_chan;
          pitch_nxt   = in_pitch;
          vel_nxt     = in_vel;
          idx_nxt     = '0;
          dv_nxt      = 1'b0;
          match_v_nxt = 1'b0;
          blank_v_nxt = 1'b0;
          unique case (in_func)
            mnl_pkg::FUNC_FLUSH: begin
              mask_nxt  = in_flush_mask;
              state_nxt = ST_REL;
            end
            mnl_pkg::FUNC_NOTE_OFF: begin
              if (!active) begin
                pend_nxt   = '{1'b0, in_chan, in_pitch, in_vel};
                pend_v_nxt = 1'b1;
                state_nxt  = ST_FIN;
              end
            end
            mnl_pkg::FUNC_NOTE_ON: begin
              if (!active) begin
                pend_nxt   = '{1'b1, in_chan, in_pitch, in_vel};
                pend_v_nxt = 1'b1;
                state_nxt  = ST_FIN;
              end else if (in_vel != '0) begin
                if (trig) begin
                  mask_nxt  = (irq_mode_r == mnl_pkg::IRQ_ALL) ? 16'hffff :
                              (16'd1 << in_chan);
                  state_nxt = ST_REL;
                end else if (poly_mode_r) begin
                  state_nxt = ST_POLY;
                end else begin
                  idx_nxt   = IW'(in_chan);
                  state_nxt = ST_MONO_RD;
                end
              end
            end
            default: ;
          endcase
        end
      end

      ST_REL, ST_POLY: begin
        if (dv_r && adv) begin
          if (state_r == ST_REL) begin
            if (hit) begin
              if (pend_v_r) begin
                out_valid_nxt = 1'b1;
                out_nxt       = pend_r;
                out_last_nxt  = 1'b0;
              end
              pend_nxt             = '{1'b0, rd_chan, rd_note, 7'd0};
              pend_v_nxt           = 1'b1;
              valid_nxt[idx_d_r]   = 1'b0;
            end
          end else begin
            if (valid_r[idx_d_r] && (rd_chan == chan_r) && (rd_note == pitch_r)) begin
              match_v_nxt = 1'b1;
              match_nxt   = idx_d_r;
            end
            if (!valid_r[idx_d_r]) begin
              blank_v_nxt = 1'b1;
              blank_nxt   = idx_d_r;
            end
          end
        end
        // advance the walk
        if (adv) begin
          if (idx_r == SCAN_END) begin
            dv_nxt = 1'b0;
          end else begin
            rd_en     = 1'b1;
            idx_d_nxt = idx_r[AW-1:0];
            dv_nxt    = 1'b1;
            idx_nxt   = idx_r + 1'b1;
          end
        end
        if ((idx_r == SCAN_END) && !dv_r) begin
          if (state_r == ST_REL) begin
            state_nxt = ST_FIN;
          end else if (match_v_r) begin
            valid_nxt[match_r] = 1'b0;
            pend_nxt           = '{1'b0, chan_r, pitch_r, 7'd0};
            pend_v_nxt         = 1'b1;
            state_nxt          = ST_FIN;
          end else if (blank_v_r) begin
            valid_nxt[blank_r] = 1'b1;
            wr_en              = 1'b1;
            wr_addr            = blank_r;
            pend_nxt           = '{1'b1, chan_r, pitch_r, vel_r};
            pend_v_nxt         = 1'b1;
            state_nxt          = ST_FIN;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_MONO_RD: begin
        rd_en     = 1'b1;
        state_nxt = ST_MONO_CHK;
      end

      ST_MONO_CHK: begin
        wr_en                = 1'b1;
        valid_nxt[mono_addr] = 1'b1;
        if (same) begin
          state_nxt = ST_IDLE;
        end else if (valid_r[mono_addr]) begin
          pend_nxt   = '{1'b0, chan_r, rd_note, 7'd0};
          pend_v_nxt = 1'b1;
          state_nxt  = ST_MONO_ON;
        end else begin
          pend_nxt   = '{1'b1, chan_r, pitch_r, vel_r};
          pend_v_nxt = 1'b1;
          state_nxt  = ST_FIN;
        end
      end

      ST_MONO_ON: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = pend_r;
          out_last_nxt  = 1'b0;
          pend_nxt      = '{1'b1, chan_r, pitch_r, vel_r};
          state_nxt     = ST_FIN;
        end
      end

      ST_FIN: begin
        if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = pend_r;
          out_last_nxt  = 1'b1;
          pend_v_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_mode_r <= 1'b0;
      chan_lo_r   <= '0;
      chan_hi_r   <= '0;
      irq_mode_r  <= mnl_pkg::IRQ_OFF;
      note_lo_r   <= '0;
      note_hi_r   <= 7'd127;
      vel_lo_r    <= '0;
      vel_hi_r    <= 7'd127;
    end else if (cfg_wr && pready) begin
      unique case (paddr[4:2])
        mnl_pkg::REG_POLY_MODE: poly_mode_r <= pwdata[0];
        mnl_pkg::REG_CHAN_LOW:  chan_lo_r   <= pwdata[3:0];
        mnl_pkg::REG_CHAN_HIGH: chan_hi_r   <= pwdata[3:0];
        mnl_pkg::REG_IRQ_MODE:  irq_mode_r  <= pwdata[1:0];
        mnl_pkg::REG_NOTE_LOW:  note_lo_r   <= pwdata[6:0];
        mnl_pkg::REG_NOTE_HIGH: note_hi_r   <= pwdata[6:0];
        mnl_pkg::REG_VEL_LOW:   vel_lo_r    <= pwdata[6:0];
        mnl_pkg::REG_VEL_HIGH:  vel_hi_r    <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dv_r        <= 1'b0;
      match_v_r   <= 1'b0;
      blank_v_r   <= 1'b0;
      valid_r     <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dv_r        <= dv_nxt;
      match_v_r   <= match_v_nxt;
      blank_v_r   <= blank_v_nxt;
      valid_r     <= valid_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chan_r     <= chan_nxt;
    pitch_r    <= pitch_nxt;
    vel_r      <= vel_nxt;
    mask_r     <= mask_nxt;
    idx_r      <= idx_nxt;
    idx_d_r    <= idx_d_nxt;
    match_r    <= match_nxt;
    blank_r    <= blank_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[idx_r[AW-1:0]];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_is_note_on = out_r.is_note_on;
  assign out_chan       = out_r.chan;
  assign out_pitch      = out_r.pitch;
  assign out_vel        = out_r.vel;
  assign out_last       = out_last_r;

endmodule

// ===== design/mnl_checker.sv =====
// ----------------------------------------------------------------------------
// mnl_checker
// Port-level checks for the MIDI note latch, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mnl_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_is_note_on,
  input logic [3:0] out_chan,
  input logic [6:0] out_pitch,
  input logic [6:0] out_vel,
  input logic       out_last,
  input logic       pready
);

  logic [19:0] out_beat;

  assign out_beat = {out_is_note_on, out_chan, out_pitch, out_vel, out_last};

  // an idle block may only hold the final beat of an item
  `MNL_ASSERT_IMPLY(a_idle_last, clk, rst_n, !in_stall && out_valid, out_last)

  `MNL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_beat))

  `MNL_ASSERT_IMPLY(a_pready_high, clk, rst_n, 1'b1, pready)

endmodule

bind midi_note_latch mnl_checker u_mnl_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_is_note_on (out_is_note_on),
  .out_chan       (out_chan),
  .out_pitch      (out_pitch),
  .out_vel        (out_vel),
  .out_last       (out_last),
  .pready         (pready)
);
